[src/crc32_record_seal_verify_assert.svh]
// Assertion macros for the CRC-32 record seal/verify block.
// Used by the port checker; no other dependencies.
`ifndef CRC32_RECORD_SEAL_VERIFY_ASSERT_SVH
`define CRC32_RECORD_SEAL_VERIFY_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define CRSV_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define CRSV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/crsv_pkg.sv]
// Shared types and constants for the CRC-32 record seal/verify block.
// No dependencies.
package crsv_pkg;

  localparam int unsigned SECTOR_BYTES_DEF = 8192;
  localparam int unsigned HDR_BYTES        = 8;
  localparam int unsigned STATUS_W         = 3;
  localparam int unsigned CRC_W            = 32;
  localparam int unsigned COUNT_W          = 13;

  localparam logic [CRC_W-1:0] CRC_INIT  = 32'hFFFF_FFFF;
  localparam logic [CRC_W-1:0] CRC_POLY  = 32'hEDB8_8320;
  localparam logic [CRC_W-1:0] REC_MAGIC = 32'hCA11_0E55;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_INVALID      = 3'd1,
    ST_NOT_FOUND    = 3'd2,
    ST_MISMATCH     = 3'd3,
    ST_BUF_OVERFLOW = 3'd4
  } status_t;

endpackage

[src/crsv_crc8.sv]
// One-byte step of reflected CRC-32 (poly EDB88320), eight bit steps unrolled.
// Depends on crsv_pkg.
module crsv_crc8 (
  input  logic [crsv_pkg::CRC_W-1:0] crc_in,
  input  logic [7:0]                 data,
  output logic [crsv_pkg::CRC_W-1:0] crc_out
);
  import crsv_pkg::*;

  logic [CRC_W-1:0] c;

  always_comb begin
    c = crc_in ^ {{(CRC_W-8){1'b0}}, data};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : '0);
    end
    crc_out = c;
  end

endmodule

[src/crc32_record_seal_verify.sv]
// CRC-32 record seal/verify. Takes one byte per clock cycle with no bubbles
// between bytes or records as long as results are taken; the result of a
// record is held in a single output register and appears the cycle after its
// last byte is transferred. While a result waits with out_ready low, in_ready
// is low and input stalls. The eight-bit CRC step is combinational. Verify mode
// expects an 8-byte header (magic, then CRC, both little endian) before
// the payload; seal mode treats every byte as payload. Payload beyond
// SECTOR_BYTES - 8 sets overflow. Depends on crsv_pkg and crsv_crc8.
module crc32_record_seal_verify #(
  parameter int unsigned SECTOR_BYTES = crsv_pkg::SECTOR_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_mode,
  input  logic [7:0]                    in_data_byte,
  input  logic                          in_last_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [crsv_pkg::STATUS_W-1:0] out_status,
  output logic [crsv_pkg::CRC_W-1:0]    out_crc_value,
  output logic [crsv_pkg::COUNT_W-1:0]  out_payload_count
);
  import crsv_pkg::*;

  localparam int unsigned LIMIT = SECTOR_BYTES - HDR_BYTES;
  localparam int unsigned IDX_W = $clog2(SECTOR_BYTES + 1);

  logic [IDX_W-1:0] idx_r,  idx_nxt;
  logic [CRC_W-1:0] crc_r,  crc_nxt;
  logic [63:0]      hdr_r,  hdr_nxt;
  logic             mode_r, mode_nxt;
  logic             ovf_r,  ovf_nxt;

  logic             out_valid_r;
  status_t          status_r, status_nxt;
  logic [CRC_W-1:0] crc_out_r, crc_out_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;

  logic             accept;
  logic             first;
  logic [IDX_W-1:0] hdr_len;
  logic [CRC_W-1:0] crc_base, crc_step;
  logic [63:0]      hdr_base, hdr_new;
  logic             ovf_base, ovf_new;
  logic [IDX_W-1:0] idx_new;
  logic [CRC_W-1:0] crc_new;
  logic [IDX_W-1:0] count;
  logic             in_hdr;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign first    = (idx_r == '0);
  assign mode_nxt = first ? in_mode : mode_r;
  assign hdr_len  = mode_nxt ? '0 : IDX_W'(HDR_BYTES);
  assign crc_base = first ? CRC_INIT : crc_r;
  assign hdr_base = first ? '0 : hdr_r;
  assign ovf_base = first ? 1'b0 : ovf_r;
  assign in_hdr   = !mode_nxt && (idx_r < IDX_W'(HDR_BYTES));

  crsv_crc8 u_crc8 (
    .crc_in  (crc_base),
    .data    (in_data_byte),
    .crc_out (crc_step)
  );

  always_comb begin
    hdr_new = hdr_base;
    crc_new = crc_base;
    ovf_new = ovf_base;
    idx_new = idx_r;
    if (in_hdr) begin
      hdr_new = hdr_base | (64'(in_data_byte) << {idx_r[2:0], 3'b000});
      idx_new = idx_r + IDX_W'(1);
    end else if ((idx_r - hdr_len) < IDX_W'(LIMIT)) begin
      crc_new = crc_step;
      idx_new = idx_r + IDX_W'(1);
    end else begin
      ovf_new = 1'b1;
    end

    count       = (idx_new >= hdr_len) ? (idx_new - hdr_len) : '0;
    crc_out_nxt = ~crc_new;
    count_nxt   = COUNT_W'(32'(count));

    if (mode_nxt) begin
      if (count == '0)               status_nxt = ST_INVALID;
      else if (ovf_new)              status_nxt = ST_BUF_OVERFLOW;
      else                           status_nxt = ST_OK;
    end else begin
      if (idx_new < IDX_W'(HDR_BYTES))       status_nxt = ST_NOT_FOUND;
      else if (count == '0)                  status_nxt = ST_INVALID;
      else if (ovf_new)                      status_nxt = ST_BUF_OVERFLOW;
      else if (hdr_new[31:0] != REC_MAGIC)   status_nxt = ST_NOT_FOUND;
      else if (crc_out_nxt != hdr_new[63:32]) status_nxt = ST_MISMATCH;
      else                                   status_nxt = ST_OK;
    end

    if (in_last_byte) begin
      idx_nxt = '0;
      crc_nxt = CRC_INIT;
      hdr_nxt = '0;
      ovf_nxt = 1'b0;
    end else begin
      idx_nxt = idx_new;
      crc_nxt = crc_new;
      hdr_nxt = hdr_new;
      ovf_nxt = ovf_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      crc_r       <= CRC_INIT;
      hdr_r       <= '0;
      mode_r      <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        idx_r  <= idx_nxt;
        crc_r  <= crc_nxt;
        hdr_r  <= hdr_nxt;
        mode_r <= mode_nxt;
        ovf_r  <= ovf_nxt;
      end
      if (accept && in_last_byte) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept && in_last_byte) begin
      status_r  <= status_nxt;
      crc_out_r <= crc_out_nxt;
      count_r   <= count_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_crc_value     = crc_out_r;
  assign out_payload_count = count_r;

endmodule

[src/crsv_checker.sv]
// Port-level checker for crc32_record_seal_verify, with its bind.
// Depends on crsv_pkg and crc32_record_seal_verify_assert.svh.
`include "crc32_record_seal_verify_assert.svh"

module crsv_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [crsv_pkg::STATUS_W-1:0] out_status,
  input logic [crsv_pkg::CRC_W-1:0]    out_crc_value,
  input logic [crsv_pkg::COUNT_W-1:0]  out_payload_count
);
  import crsv_pkg::*;

  // stalled result must hold until transfer
  `CRSV_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_status) && $stable(out_crc_value)
      && $stable(out_payload_count),
    "result changed while stalled")

  `CRSV_ASSERT_NOW(a_status_range, clk, rst_n, out_valid,
    out_status <= ST_BUF_OVERFLOW, "status code out of range")

  // empty payload: nothing counted, CRC over nothing is zero
  `CRSV_ASSERT_NOW(a_empty_payload, clk, rst_n, out_valid && out_status == ST_INVALID,
    out_payload_count == '0 && out_crc_value == '0,
    "empty-payload status with payload counted")

  // the output register frees input flow whenever it is empty
  `CRSV_ASSERT_NOW(a_ready_when_empty, clk, rst_n, !out_valid, in_ready,
    "input stalled with empty output")

endmodule

bind crc32_record_seal_verify crsv_checker u_crsv_checker (.*);
